// ===== rtl/btad_pkg.sv =====
// Package for the binary to ASCII digit converter.
// Holds the sequencer states, the arithmetic unit control bundle, constants
// and the digit to ASCII mapping. It depends on nothing.
`default_nettype none

package btad_pkg;

  // Radix select codes
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // Reciprocal of ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for 32-bit v
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  // ASCII bases
  localparam logic [6:0] ASCII_ZERO     = 7'h30;  // '0'
  localparam logic [6:0] ASCII_HEX_BASE = 7'h37;  // 'A' - 10

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_EMIT
  } state_e;

  // Control from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic load;   // take a new value and radix
    logic mul;    // form the reciprocal product
    logic split;  // peel off one digit and keep the rest
  } unit_ctl_t;

  // Map one digit (0 to 15) to its ASCII character
  function automatic logic [6:0] to_ascii(input logic [3:0] digit);
    logic [6:0] base;
    base = (digit < 4'd10) ? ASCII_ZERO : ASCII_HEX_BASE;
    return base + {3'b000, digit};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/btad_digit_unit.sv =====
// Shared arithmetic unit: peels one digit off the working value per pass.
// Decimal uses a registered reciprocal multiply, hex a nibble shift.
// Depends on btad_pkg.
`default_nettype none

module btad_digit_unit
  import btad_pkg::*;
(
  input  wire logic        clk_i,
  input  wire unit_ctl_t   ctl_i,
  input  wire logic        op_i,
  input  wire logic [31:0] value_i,
  output logic      [3:0]  digit_o
);

  logic        op_q;
  logic [31:0] v_q;
  logic [31:0] v_d;
  logic [63:0] prod_q;
  logic [31:0] quot;
  logic [31:0] ten_quot;
  logic [31:0] diff;

  // Quotient and remainder by ten from the registered product
  assign quot     = {3'b000, prod_q[63:RECIP10_SHIFT]};
  assign ten_quot = (quot << 3) + (quot << 1);
  assign diff     = v_q - ten_quot;

  // Select digit and remaining value for the radix
  always_comb begin
    if (op_q == OP_HEX) begin
      digit_o = v_q[3:0];
      v_d     = v_q >> 4;
    end else begin
      digit_o = diff[3:0];
      v_d     = quot;
    end
  end

  // Load, multiply and advance the working value
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q <= op_i;
      v_q  <= value_i;
    end else if (ctl_i.split) begin
      v_q <= v_d;
    end
    if (ctl_i.mul) begin
      prod_q <= 64'(v_q) * 64'(RECIP10);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/btad_digit_buf.sv =====
// Digit store: digits are written least significant first and read back
// in any order as ASCII characters. Depends on btad_pkg.
`default_nettype none

module btad_digit_buf
  import btad_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IW    = 3
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [IW-1:0] wr_idx_i,
  input  wire logic [3:0]    wr_digit_i,
  input  wire logic [IW-1:0] rd_idx_i,
  output logic      [6:0]    ch_o
);

  logic [3:0] digits_q [DEPTH];

  // Store one digit
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      digits_q[wr_idx_i] <= wr_digit_i;
    end
  end

  // Read out as a character
  assign ch_o = to_ascii(digits_q[rd_idx_i]);

endmodule

`default_nettype wire

// ===== rtl/binary_to_ascii_digits.sv =====
// Binary to ASCII digit converter: one item (value, radix, count) becomes
// count characters, most significant first, last set on the final one. An
// item with N digits (count saturated to MAX_DIGITS) is busy once it is
// taken: a multiply and a split step per digit on the shared reciprocal
// multiplier and shifter, then one character per cycle when the output is
// not stalled. Input stall stays high until the final character is taken.
// Depends on btad_pkg, btad_digit_unit and btad_digit_buf.
`default_nettype none

module binary_to_ascii_digits
  import btad_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [31:0] value_i,
  input  wire logic [3:0]  digit_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [6:0]  ch_o,
  output logic             last_o
);

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_e          state_q, state_d;
  logic   [CW-1:0] cnt_q, cnt_d;
  logic   [IW-1:0] idx_q, idx_d;
  logic   [CW-1:0] sat_count;
  logic            in_accept;
  logic            out_accept;
  logic   [3:0]    digit;
  unit_ctl_t       ctl;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_accept = out_valid_o && !out_stall_i;

  // Clamp the requested count
  assign sat_count = (digit_count_i > 4'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                      : CW'(digit_count_i);

  // Next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (sat_count != '0)) begin
          state_d = ST_MUL;
          cnt_d   = sat_count;
          idx_d   = '0;
        end
      end
      ST_MUL: begin
        state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (CW'(idx_q) == cnt_q - CW'(1)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MUL;
          idx_d   = idx_q + IW'(1);
        end
      end
      ST_EMIT: begin
        if (out_accept) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctl.load    = in_accept;
    ctl.mul     = (state_q == ST_MUL);
    ctl.split   = (state_q == ST_SPLIT);
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    last_o      = (state_q == ST_EMIT) && (idx_q == '0);
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  btad_digit_unit u_unit (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .op_i    (op_i),
    .value_i (value_i),
    .digit_o (digit)
  );

  btad_digit_buf #(
    .DEPTH (MAX_DIGITS),
    .IW    (IW)
  ) u_buf (
    .clk_i      (clk_i),
    .wr_en_i    (ctl.split),
    .wr_idx_i   (idx_q),
    .wr_digit_i (digit),
    .rd_idx_i   (idx_q),
    .ch_o       (ch_o)
  );

endmodule

`default_nettype wire

// ===== rtl/btad_checker.sv =====
// Port-level checks for the binary to ASCII digit converter, bound to the
// top level. Depends only on the top level's ports.
`default_nettype none

module btad_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [3:0]  digit_count_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [6:0]  ch_o,
  input wire logic        last_o
);

  // A nonzero item keeps the input busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (digit_count_i != 4'd0)) |=> in_stall_o)
    else $error("input not busy after taking an item");

  // A zero-count item produces no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (digit_count_i == 4'd0)) |=> !out_valid_o)
    else $error("character after zero-count item");

  // Characters only while the input is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("character shown while input is free");

  // Characters are decimal or uppercase hex digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ch_o >= 7'h30 && ch_o <= 7'h39) ||
                     (ch_o >= 7'h41 && ch_o <= 7'h46)))
    else $error("character out of digit range");

  // The run ends after its final character is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("character after final one");

endmodule

bind binary_to_ascii_digits btad_checker u_btad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .digit_count_i (digit_count_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .ch_o          (ch_o),
  .last_o        (last_o)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for binary_to_ascii_digits: a directed table, then random
// bursts, checked character by character against typed text or a digit predictor.
// Depends on btad_pkg and the RTL of the converter.

module tb_top;
  import btad_pkg::*;

  localparam int MAX_DIG      = 8;
  localparam int RANDOM_ITEMS = 388;
  localparam int HOLD_CYCLES  = 220;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [6:0] CH_ZERO  = 7'h30;  // '0'
  localparam logic [6:0] CH_ALPHA = 7'h37;  // 'A' minus ten

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } ascii_char_t;

  // Receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC,
    RX_HOLD
  } rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        op_i          = OP_DEC;
  logic [31:0] value_i       = '0;
  logic [3:0]  digit_count_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [6:0]  ch_o;
  logic        last_o;

  // Hand-typed expectation travelling with the item on offer
  bit          row_typed = 1'b0;
  bit   [63:0] row_text  = '0;

  ascii_char_t char_q[$];
  int          cycles;
  int          mismatches;
  int          items_taken;
  int          hex_items;
  int          empty_items;
  int          clipped_items;
  int          chars_seen;
  int          hold_offs;

  binary_to_ascii_digits dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ch_o          (ch_o),
    .last_o        (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Queue the characters of one item, most significant digit first
  function automatic void spell_digits(input logic radix, input logic [31:0] value,
                                       input logic [3:0] count);
    logic [6:0]  chars [MAX_DIG];
    logic [31:0] rest;
    logic [3:0]  d;
    int          n;
    ascii_char_t c;
    n = (count > MAX_DIG) ? MAX_DIG : int'(count);
    rest = value;
    for (int i = 0; i < n; i++) begin
      if (radix == OP_HEX) begin
        d = rest[3:0];
        rest = rest >> 4;
      end else begin
        d = 4'(rest % 10);
        rest = rest / 10;
      end
      chars[i] = (d < 4'd10) ? CH_ZERO + 7'(d) : CH_ALPHA + 7'(d);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch = chars[i];
      c.last = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  // Queue a typed string; its length equals the saturated count
  function automatic void queue_text(input logic [3:0] count, input bit [63:0] text);
    int          n;
    ascii_char_t c;
    n = (count > MAX_DIG) ? MAX_DIG : int'(count);
    for (int i = 0; i < n; i++) begin
      c.ch = text[8 * (n - 1 - i) +: 7];
      c.last = (i == n - 1);
      char_q.push_back(c);
    end
  endfunction

  // Offer one item and hold it until taken
  task automatic offer_item(input logic radix, input logic [31:0] value,
                            input logic [3:0] count, input bit typed, input bit [63:0] text);
    in_valid_i    <= 1'b1;
    op_i          <= radix;
    value_i       <= value;
    digit_count_i <= count;
    row_typed     <= typed;
    row_text      <= text;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters pending", cycles, char_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Check taken characters, then predict for a taken item
  always @(posedge clk_i) begin : scoreboard
    ascii_char_t got;
    ascii_char_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.ch = ch_o;
        got.last = last_o;
        chars_seen++;
        if (char_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected char %h last %b, nothing pending", got.ch, got.last);
        end else begin
          want = char_q.pop_front();
          if (got.ch !== want.ch || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.ch, want.last, got.ch, got.last);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        items_taken++;
        if (op_i == OP_HEX) hex_items++;
        if (digit_count_i == 4'd0) empty_items++;
        if (digit_count_i > MAX_DIG) clipped_items++;
        if (row_typed) queue_text(digit_count_i, row_text);
        else spell_digits(op_i, value_i, digit_count_i);
      end
    end
  end

  // Stall the output on changing patterns, with a long hold-off now and then
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       seg;
    seg = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      span = $urandom_range(40, 300);
      mode = (seg % 8 == 3) ? RX_HOLD : rx_mode_e'($urandom_range(0, 3));
      if (mode == RX_HOLD) begin
        hold_offs++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        for (int k = 0; k < span; k++) begin
          case (mode)
            RX_FREE:   out_stall_i <= 1'b0;
            RX_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  out_stall_i <= ($urandom_range(0, 9) < 7);
            default:   out_stall_i <= (k % 5 < 2);
          endcase
          @(posedge clk_i);
        end
      end
      seg++;
    end
  end

  initial begin : stimulus
    logic            t_op [$];
    logic [31:0]     t_val [$];
    logic [3:0]      t_cnt [$];
    bit              t_typed [$];
    bit   [63:0]     t_text [$];
    logic            radix;
    logic [31:0]     value;
    logic [3:0]      count;
    longint unsigned p;
    int              sent;
    int              burst;

    // Directed table: radix, value, count, typed?, expected text
    t_op.push_back(OP_DEC); t_val.push_back(32'd0);          t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("00000000");
    t_op.push_back(OP_DEC); t_val.push_back(32'hFFFF_FFFF);  t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("94967295");
    t_op.push_back(OP_HEX); t_val.push_back(32'hFFFF_FFFF);  t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("FFFFFFFF");
    t_op.push_back(OP_HEX); t_val.push_back(32'd0);          t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("00000000");
    t_op.push_back(OP_DEC); t_val.push_back(32'd12345);      t_cnt.push_back(4'd0);
    t_typed.push_back(1'b1); t_text.push_back("");
    t_op.push_back(OP_HEX); t_val.push_back(32'hDEAD_BEEF);  t_cnt.push_back(4'd0);
    t_typed.push_back(1'b1); t_text.push_back("");
    t_op.push_back(OP_HEX); t_val.push_back(32'hDEAD_BEEF);  t_cnt.push_back(4'd15);
    t_typed.push_back(1'b1); t_text.push_back("DEADBEEF");
    t_op.push_back(OP_DEC); t_val.push_back(32'd123456789);  t_cnt.push_back(4'd9);
    t_typed.push_back(1'b1); t_text.push_back("23456789");
    t_op.push_back(OP_DEC); t_val.push_back(32'd7);          t_cnt.push_back(4'd1);
    t_typed.push_back(1'b1); t_text.push_back("7");
    t_op.push_back(OP_HEX); t_val.push_back(32'hA);          t_cnt.push_back(4'd1);
    t_typed.push_back(1'b1); t_text.push_back("A");
    t_op.push_back(OP_HEX); t_val.push_back(32'h1234_5678);  t_cnt.push_back(4'd4);
    t_typed.push_back(1'b1); t_text.push_back("5678");
    t_op.push_back(OP_DEC); t_val.push_back(32'd1000);       t_cnt.push_back(4'd3);
    t_typed.push_back(1'b1); t_text.push_back("000");
    t_op.push_back(OP_DEC); t_val.push_back(32'd99999999);   t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("99999999");
    t_op.push_back(OP_DEC); t_val.push_back(32'd100000000);  t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("00000000");
    t_op.push_back(OP_HEX); t_val.push_back(32'h89AB_CDEF);  t_cnt.push_back(4'd8);
    t_typed.push_back(1'b1); t_text.push_back("89ABCDEF");
    t_op.push_back(OP_HEX); t_val.push_back(32'hF);          t_cnt.push_back(4'd2);
    t_typed.push_back(1'b1); t_text.push_back("0F");
    t_op.push_back(OP_DEC); t_val.push_back(32'd9);          t_cnt.push_back(4'd2);
    t_typed.push_back(1'b1); t_text.push_back("09");
    t_op.push_back(OP_DEC); t_val.push_back(32'd42);         t_cnt.push_back(4'd5);
    t_typed.push_back(1'b0); t_text.push_back('0);
    t_op.push_back(OP_DEC); t_val.push_back(32'h8000_0000);  t_cnt.push_back(4'd8);
    t_typed.push_back(1'b0); t_text.push_back('0);
    t_op.push_back(OP_HEX); t_val.push_back(32'h5A5A_5A5A);  t_cnt.push_back(4'd12);
    t_typed.push_back(1'b0); t_text.push_back('0);
    t_op.push_back(OP_DEC); t_val.push_back(32'h5555_5555);  t_cnt.push_back(4'd7);
    t_typed.push_back(1'b0); t_text.push_back('0);
    t_op.push_back(OP_HEX); t_val.push_back(32'h0F1E_2D3C);  t_cnt.push_back(4'd3);
    t_typed.push_back(1'b0); t_text.push_back('0);

    // Hold reset, then release on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table with short gaps
    for (int r = 0; r < t_op.size(); r++) begin
      offer_item(t_op[r], t_val[r], t_cnt[r], t_typed[r], t_text[r]);
      idle_for($urandom_range(0, 2));
    end

    // Random bursts of items with random gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        radix = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0: value = 32'($urandom_range(0, 99));
          1: begin
            p = 64'd1;
            repeat ($urandom_range(1, 9)) p = p * 10;
            value = 32'(p - $urandom_range(0, 1));
          end
          2: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
          default: value = $urandom();
        endcase
        count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        offer_item(radix, value, count, 1'b0, '0);
        sent++;
      end
      idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end

    // Drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (char_q.size() != 0) $display("%0d characters never arrived", char_q.size());
    $display("Converted %0d items (%0d hex, %0d empty, %0d clipped), %0d characters checked",
             items_taken, hex_items, empty_items, clipped_items, chars_seen);
    $display("Receiver held off %0d times; %0d mismatches in %0d cycles",
             hold_offs, mismatches, cycles);
    if (mismatches == 0 && char_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/btad_pkg.sv
rtl/btad_digit_unit.sv
rtl/btad_digit_buf.sv
rtl/binary_to_ascii_digits.sv
rtl/btad_checker.sv
tb/tb_top.sv
